>>> hdl/tiny_byte_interpreter_core_macros.svh
// Assertion macros for the tiny byte interpreter core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TINY_BYTE_INTERPRETER_CORE_MACROS_SVH
`define TINY_BYTE_INTERPRETER_CORE_MACROS_SVH

// same-cycle implication
`define TBI_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define TBI_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hdl/tbi_pkg.sv
// Shared codes, word layout and controller/datapath interface types.
// No dependencies; used by every module of the interpreter core.
`default_nettype none

package tbi_pkg;

   // request modes
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_START = 2'd1;
   localparam logic [1:0] MODE_STEP  = 2'd2;

   // opcodes
   localparam logic [3:0] OP_MOVE = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_SUB  = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_DIV  = 4'd4;
   localparam logic [3:0] OP_JUMP = 4'd5;
   localparam logic [3:0] OP_EQ   = 4'd6;
   localparam logic [3:0] OP_NE   = 4'd7;
   localparam logic [3:0] OP_GT   = 4'd8;
   localparam logic [3:0] OP_LT   = 4'd9;
   localparam logic [3:0] OP_OUT  = 4'd10;
   localparam logic [3:0] OP_IN   = 4'd11;

   // step status
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_DIV0 = 2'd1;
   localparam logic [1:0] STAT_NEG  = 2'd2;

   // operand flag bits
   localparam int FLAG_DST = 0;
   localparam int FLAG_SRC = 1;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = 3;

   typedef struct packed {
      logic [3:0] op;
      logic [1:0] flags;
      logic [7:0] a;
      logic [7:0] b;
   } word_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic fetch;
      logic read_a;
      logic read_b;
      logic exec;
      logic div_step;
      logic div_wb;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic div_go;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> hdl/tbi_controller.sv
// Sequencer of the interpreter core: one-hot state machine and divide counter.
// Depends on tbi_pkg and tiny_byte_interpreter_core_macros.svh.
`default_nettype none

`include "tiny_byte_interpreter_core_macros.svh"

module tbi_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_mode,
   output logic                   req_stall,
   input  wire tbi_pkg::stat_type st,
   output tbi_pkg::cmd_type       cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_LOAD  = 9'b000000010,
      ST_FETCH = 9'b000000100,
      ST_READA = 9'b000001000,
      ST_READB = 9'b000010000,
      ST_EXEC  = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_DIVWB = 9'b010000000,
      ST_RESP  = 9'b100000000
   } state_type;

   localparam logic [tbi_pkg::DIV_CNT_W-1:0] CntLast =
      tbi_pkg::DIV_CNT_W'(tbi_pkg::DIV_STEPS - 1);

   state_type                     state_ff, state_in;
   logic [tbi_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_mode) inside
                  tbi_pkg::MODE_WRITE, tbi_pkg::MODE_START: state_in = ST_LOAD;
                  tbi_pkg::MODE_STEP: state_in = st.running ? ST_FETCH : ST_RESP;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_LOAD:  state_in = ST_RESP;
         ST_FETCH: state_in = ST_READA;
         ST_READA: state_in = ST_READB;
         ST_READB: state_in = ST_EXEC;
         ST_EXEC:  state_in = st.div_go ? ST_DIV : ST_RESP;
         ST_DIV: begin
            if (cnt_ff == CntLast) begin
               state_in = ST_DIVWB;
            end
         end
         ST_DIVWB: state_in = ST_RESP;
         ST_RESP: begin
            if (st.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_EXEC) begin
         cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.capture  = (state_ff == ST_IDLE) && req_valid;
      cmd.load     = (state_ff == ST_LOAD);
      cmd.fetch    = (state_ff == ST_FETCH);
      cmd.read_a   = (state_ff == ST_READA);
      cmd.read_b   = (state_ff == ST_READB);
      cmd.exec     = (state_ff == ST_EXEC);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.div_wb   = (state_ff == ST_DIVWB);
      cmd.respond  = (state_ff == ST_RESP) && st.out_free;
   end

   `TBI_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "accepted word did not make the core busy")
   `TBI_ASSERT_NEXT(a_div_length, clock, reset, state_ff == ST_DIV && cnt_ff == CntLast, state_ff == ST_DIVWB, "divide did not end after its last step")
   `TBI_ASSERT_IMPLY(a_exec_order, clock, reset, state_ff == ST_EXEC, $past(state_ff) == ST_READB, "execute entered without operand reads")
   `TBI_ASSERT_NEXT(a_resp_release, clock, reset, cmd.respond, state_ff == ST_IDLE && !req_stall, "core not idle after result handoff")

endmodule

`default_nettype wire

>>> hdl/tbi_datapath.sv
// Datapath of the interpreter core: program and variable stores, operand
// registers, ALU, iterative divider, program counter and result register.
// Depends on tbi_pkg; driven by tbi_controller commands.
`default_nettype none

module tbi_datapath #(
   parameter int PROGRAM_DEPTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tbi_pkg::cmd_type                     cmd,
   output tbi_pkg::stat_type                         st,
   input  wire logic        [1:0]                    req_mode,
   input  wire logic        [7:0]                    req_address,
   input  wire logic        [3:0]                    req_opcode,
   input  wire logic        [1:0]                    req_operand_flags,
   input  wire logic signed [7:0]                    req_first_operand,
   input  wire logic signed [7:0]                    req_second_operand,
   input  wire logic        [8:0]                    req_program_length,
   input  wire logic        [7:0]                    req_input_char,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_out_valid,
   output logic             [7:0]                    rsp_out_char,
   output logic                                      rsp_input_used,
   output logic                                      rsp_running,
   output logic             [1:0]                    rsp_status,
   output logic             [$clog2(PROGRAM_DEPTH+1)-1:0] rsp_next_pc
);

   localparam int IdxW = $clog2(PROGRAM_DEPTH);
   localparam int PcW  = $clog2(PROGRAM_DEPTH + 1);
   localparam int CmpW = PcW + 8;
   localparam int NxtW = CmpW + 1;

   // captured request
   logic [1:0]        mode_ff;
   logic [7:0]        addr_ff;
   tbi_pkg::word_type wload_ff;
   logic [8:0]        plen_ff;
   logic [7:0]        ichar_ff;

   // architectural state
   logic [PcW-1:0] pc_ff, len_ff;
   logic           run_ff;

   // stores
   tbi_pkg::word_type prog_mem [PROGRAM_DEPTH];
   tbi_pkg::word_type word_ff;
   logic [7:0]        var_mem [256];
   logic [255:0]      var_vld_ff;
   logic [7:0]        var_data_ff;
   logic              var_hit_ff;

   // operands and divider
   logic [7:0] x_ff;
   logic [7:0] dv_ff, rem_ff, quo_ff;
   logic       neg_ff;

   // step report
   logic       ovalid_ff, iused_ff;
   logic [7:0] ochar_ff;
   logic [1:0] status_ff;

   // result register
   logic           rsp_valid_ff, rsp_ovalid_ff, rsp_iused_ff, rsp_running_ff;
   logic [7:0]     rsp_ochar_ff;
   logic [1:0]     rsp_status_ff;
   logic [PcW-1:0] rsp_pc_ff;

   logic           running;
   logic [IdxW-1:0] pc_idx, load_idx;
   logic           addr_ok;
   logic [PcW-1:0] len_sat;
   logic [7:0]     var_value, y_val, var_ra;
   logic [7:0]     alu_val, prod, wb_value, quot;
   logic           is_wr_op, taken, jump, is_div, div_go, div0, commit, wb_en;
   logic [NxtW-1:0] base_ext, off_ext, target;
   logic           tgt_neg, tgt_over;
   logic [PcW-1:0] pc_new;
   logic           prog_we, var_we;
   logic [IdxW-1:0] prog_wa;
   tbi_pkg::word_type prog_wd;
   logic [8:0]     trial;
   logic           fits;

   assign running  = run_ff && (pc_ff < len_ff);
   assign pc_idx   = pc_ff[IdxW-1:0];
   assign addr_ok  = CmpW'(addr_ff) < CmpW'(PROGRAM_DEPTH);
   assign load_idx = IdxW'(addr_ff);
   assign len_sat  = (CmpW'(plen_ff) > CmpW'(PROGRAM_DEPTH)) ?
                     PcW'(PROGRAM_DEPTH) : PcW'(plen_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff        <= req_mode;
         addr_ff        <= req_address;
         wload_ff.op    <= req_opcode;
         wload_ff.flags <= req_operand_flags;
         wload_ff.a     <= req_first_operand;
         wload_ff.b     <= req_second_operand;
         plen_ff        <= req_program_length;
         ichar_ff       <= req_input_char;
      end
   end

   // operand values
   assign var_value = var_hit_ff ? var_data_ff : 8'd0;
   assign y_val     = word_ff.flags[tbi_pkg::FLAG_SRC] ? var_value : word_ff.b;
   assign var_ra    = cmd.read_b ? word_ff.b : word_ff.a;

   always_ff @(posedge clock) begin
      if (cmd.read_b) begin
         x_ff <= word_ff.flags[tbi_pkg::FLAG_DST] ? var_value : word_ff.a;
      end
   end

   // ALU and branch decode
   assign prod = x_ff * y_val;

   always_comb begin
      alu_val  = y_val;
      is_wr_op = 1'b0;
      taken    = 1'b0;
      unique case (word_ff.op) inside
         tbi_pkg::OP_MOVE: begin alu_val = y_val;        is_wr_op = 1'b1; end
         tbi_pkg::OP_ADD:  begin alu_val = x_ff + y_val; is_wr_op = 1'b1; end
         tbi_pkg::OP_SUB:  begin alu_val = x_ff - y_val; is_wr_op = 1'b1; end
         tbi_pkg::OP_MUL:  begin alu_val = prod;         is_wr_op = 1'b1; end
         tbi_pkg::OP_IN:   begin alu_val = ichar_ff;     is_wr_op = 1'b1; end
         tbi_pkg::OP_EQ:   taken = (x_ff == 8'd0);
         tbi_pkg::OP_NE:   taken = (x_ff != 8'd0);
         tbi_pkg::OP_GT:   taken = !x_ff[7] && (x_ff != 8'd0);
         tbi_pkg::OP_LT:   taken = x_ff[7];
         default: ;
      endcase
   end

   assign is_div = (word_ff.op == tbi_pkg::OP_DIV);
   assign div_go = cmd.exec && is_div && (y_val != 8'd0);
   assign div0   = cmd.exec && is_div && (y_val == 8'd0);
   assign commit = (cmd.exec && !is_div) || cmd.div_wb;
   assign jump   = cmd.exec && (word_ff.op == tbi_pkg::OP_JUMP);
   assign wb_en  = commit && (cmd.div_wb || is_wr_op);

   // next counter: jump target, pc + offset or pc + 1
   assign base_ext = jump ? '0 : NxtW'(pc_ff);
   assign off_ext  = jump ? NxtW'($signed(x_ff)) :
                     (cmd.exec && taken) ? NxtW'($signed(y_val)) : NxtW'(1);
   assign target   = base_ext + off_ext;
   assign tgt_neg  = target[NxtW-1];
   assign tgt_over = target > NxtW'(PROGRAM_DEPTH);
   assign pc_new   = tgt_over ? PcW'(PROGRAM_DEPTH) : target[PcW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         len_ff <= '0;
         run_ff <= 1'b0;
      end else if (cmd.load && mode_ff == tbi_pkg::MODE_START) begin
         len_ff <= len_sat;
         pc_ff  <= '0;
         run_ff <= (len_sat != '0);
      end else if (div0) begin
         run_ff <= 1'b0;
      end else if (commit) begin
         if (tgt_neg) begin
            run_ff <= 1'b0;
         end else begin
            pc_ff <= pc_new;
         end
      end
   end

   // divider: magnitudes, one restoring step per cycle
   assign trial = {rem_ff, quo_ff[7]};
   assign fits  = trial >= {1'b0, dv_ff};
   assign quot  = neg_ff ? (8'd0 - quo_ff) : quo_ff;

   always_ff @(posedge clock) begin
      if (div_go) begin
         dv_ff  <= y_val[7] ? (8'd0 - y_val) : y_val;
         quo_ff <= x_ff[7] ? (8'd0 - x_ff) : x_ff;
         rem_ff <= '0;
         neg_ff <= x_ff[7] ^ y_val[7];
      end else if (cmd.div_step) begin
         rem_ff <= fits ? 8'(trial - {1'b0, dv_ff}) : trial[7:0];
         quo_ff <= {quo_ff[6:0], fits};
      end
   end

   assign wb_value = cmd.div_wb ? quot : alu_val;

   // program store: loads and literal write-back share one write port
   assign prog_we = (cmd.load && mode_ff == tbi_pkg::MODE_WRITE && addr_ok) ||
                    (wb_en && !word_ff.flags[tbi_pkg::FLAG_DST]);
   assign prog_wa = cmd.load ? load_idx : pc_idx;
   always_comb begin
      prog_wd = word_ff;
      if (cmd.load) begin
         prog_wd = wload_ff;
      end else begin
         prog_wd.a = wb_value;
      end
   end

   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[prog_wa] <= prog_wd;
      end
      if (cmd.fetch) begin
         word_ff <= prog_mem[pc_idx];
      end
   end

   // variable store; unwritten keys read as zero through the valid bits
   assign var_we = wb_en && word_ff.flags[tbi_pkg::FLAG_DST];

   always_ff @(posedge clock) begin
      if (var_we) begin
         var_mem[word_ff.a] <= wb_value;
      end
      if (cmd.read_a || cmd.read_b) begin
         var_data_ff <= var_mem[var_ra];
         var_hit_ff  <= var_vld_ff[var_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         var_vld_ff <= '0;
      end else if (var_we) begin
         var_vld_ff[word_ff.a] <= 1'b1;
      end
   end

   // step report
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ovalid_ff <= 1'b0;
         ochar_ff  <= 8'd0;
         iused_ff  <= 1'b0;
         status_ff <= tbi_pkg::STAT_OK;
      end else begin
         if (div0) begin
            status_ff <= tbi_pkg::STAT_DIV0;
         end else if (commit && tgt_neg) begin
            status_ff <= tbi_pkg::STAT_NEG;
         end
         if (cmd.exec && word_ff.op == tbi_pkg::OP_OUT) begin
            ovalid_ff <= 1'b1;
            ochar_ff  <= x_ff;
         end
         if (cmd.exec && word_ff.op == tbi_pkg::OP_IN) begin
            iused_ff <= 1'b1;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_ovalid_ff  <= ovalid_ff;
         rsp_ochar_ff   <= ochar_ff;
         rsp_iused_ff   <= iused_ff;
         rsp_running_ff <= running;
         rsp_status_ff  <= status_ff;
         rsp_pc_ff      <= pc_ff;
      end
   end

   assign st.running  = running;
   assign st.div_go   = div_go;
   assign st.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_valid  = rsp_ovalid_ff;
   assign rsp_out_char   = rsp_ochar_ff;
   assign rsp_input_used = rsp_iused_ff;
   assign rsp_running    = rsp_running_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_next_pc    = rsp_pc_ff;

endmodule

`default_nettype wire

>>> hdl/tiny_byte_interpreter_core.sv
// Tiny byte interpreter core: one request word in, one response word out.
// Usage:
//  - req_* channel: req_valid/req_stall handshake; a word is taken when
//    req_valid is high and req_stall is low. req_mode selects program load
//    (0), run start (1) or single instruction step (2); mode 3 is a no-op.
//  - rsp_* channel: one response word per request, held stable while
//    rsp_stall is high. A finished response waits in the output register;
//    the next request is taken once the response has been handed over to
//    that register.
//  - Path from request accept to response handoff: load and start pass a
//    load state, no-op and steps while halted go straight to the response
//    state, an executed step runs fetch, two operand reads and execute, and
//    a divide adds 8 restoring-divider steps (one quotient bit per cycle)
//    and a write-back; handoff waits while the output register is stalled.
//  - One request in flight at a time; the two operand reads share the
//    single read port of the variable store, one after the other.
//  - Reset (synchronous, active high): counter, length and run flag clear,
//    all 256 variables read as zero (per-entry valid bits); the program
//    store is left as is and must be loaded before a run.
//  - While rsp_stall holds, at most one more request runs, then req_stall stays high.
`default_nettype none

module tiny_byte_interpreter_core #(
   parameter int PROGRAM_DEPTH = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic        [1:0]                    req_mode,
   input  wire logic        [7:0]                    req_address,
   input  wire logic        [3:0]                    req_opcode,
   input  wire logic        [1:0]                    req_operand_flags,
   input  wire logic signed [7:0]                    req_first_operand,
   input  wire logic signed [7:0]                    req_second_operand,
   input  wire logic        [8:0]                    req_program_length,
   input  wire logic        [7:0]                    req_input_char,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_out_valid,
   output logic             [7:0]                    rsp_out_char,
   output logic                                      rsp_input_used,
   output logic                                      rsp_running,
   output logic             [1:0]                    rsp_status,
   output logic             [$clog2(PROGRAM_DEPTH+1)-1:0] rsp_next_pc
);

   tbi_pkg::cmd_type  cmd;
   tbi_pkg::stat_type st;

   // sequencer: decides which datapath step runs each cycle
   tbi_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // stores, ALU, divider, counter and response register
   tbi_datapath #(
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .req_mode           (req_mode),
      .req_address        (req_address),
      .req_opcode         (req_opcode),
      .req_operand_flags  (req_operand_flags),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_program_length (req_program_length),
      .req_input_char     (req_input_char),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_valid      (rsp_out_valid),
      .rsp_out_char       (rsp_out_char),
      .rsp_input_used     (rsp_input_used),
      .rsp_running        (rsp_running),
      .rsp_status         (rsp_status),
      .rsp_next_pc        (rsp_next_pc)
   );

endmodule

`default_nettype wire
